// ----- rtl/core/sgr_pkg.sv -----
// ----------------------------------------------------------------------------
// SGR decoder package
// Shared types, palettes, code classes and constants for the SGR decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

	typedef logic [23:0] color_t;
	typedef color_t pal256_t [256];

	localparam color_t DEF_FG_RESET   = 24'hD8DEE9;
	localparam color_t DEF_BG_RESET   = 24'h000000;
	localparam logic [7:0] BOLD_PCT_RESET = 8'd116;

	// floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for every p below 2**16
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam int          RECIP_SHIFT = 23;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam color_t BASE_PALETTE [16] = '{
		24'h15161E, 24'hF7768E, 24'h9ECE6A, 24'hE0AF68,
		24'h7AA2F7, 24'hBB9AF7, 24'h7DCFFF, 24'hC0CAF5,
		24'h414868, 24'hFF899D, 24'hB9F27C, 24'hF4C97A,
		24'h8DB0FF, 24'hC7A9FF, 24'h9BE8FF, 24'hF4F7FF
	};

	localparam logic [7:0] CUBE_LEVELS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

	// xterm 256-color table: 16 base entries, 6x6x6 cube, 24 grays
	function automatic pal256_t build_palette256();
		pal256_t    t;
		int         ri;
		int         gi;
		int         bi;
		logic [7:0] gray;
		ri   = 0;
		gi   = 0;
		bi   = 0;
		gray = 8'd8;
		for (int i = 0; i < 256; i++) begin
			if (i < 16) begin
				t[i] = BASE_PALETTE[i];
			end else if (i < 232) begin
				t[i] = {CUBE_LEVELS[ri], CUBE_LEVELS[gi], CUBE_LEVELS[bi]};
				bi = bi + 1;
				if (bi == 6) begin
					bi = 0;
					gi = gi + 1;
					if (gi == 6) begin
						gi = 0;
						ri = ri + 1;
					end
				end
			end else begin
				t[i] = {gray, gray, gray};
				gray = gray + 8'd10;
			end
		end
		return t;
	endfunction

	localparam pal256_t PALETTE256 = build_palette256();

	typedef enum logic [1:0] {
		CFG_DEF_FG   = 2'd0,
		CFG_DEF_BG   = 2'd1,
		CFG_BOLD_PCT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		color_t     def_fg;
		color_t     def_bg;
		logic [7:0] bold_pct;
	} cfg_t;

	typedef enum logic [3:0] {
		CLS_NONE     = 4'd0,
		CLS_RESET    = 4'd1,
		CLS_BOLD_SET = 4'd2,
		CLS_BOLD_CLR = 4'd3,
		CLS_REV_SET  = 4'd4,
		CLS_REV_CLR  = 4'd5,
		CLS_FG_PAL   = 4'd6,
		CLS_BG_PAL   = 4'd7,
		CLS_FG_DEF   = 4'd8,
		CLS_BG_DEF   = 4'd9,
		CLS_SEL_FG   = 4'd10,
		CLS_SEL_BG   = 4'd11
	} cls_t;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_SELECT = 7'b0000010,
		PH_INDEX  = 7'b0000100,
		PH_FIRST  = 7'b0001000,
		PH_RED    = 7'b0010000,
		PH_GREEN  = 7'b0100000,
		PH_BLUE   = 7'b1000000
	} phase_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       empty_seq;
		cls_t       cls;
		color_t     base_color;
		color_t     pal_color;
		logic [7:0] low8;
		logic       sel5;
		logic       sel2;
		logic       zero3;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/sgr_if.sv -----
// ----------------------------------------------------------------------------
// SGR decoder channels
// Valid/ready channel interfaces for codes, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgr_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] code;
	logic [7:0]  codes_left;
	modport source (output valid, op, code, codes_left, input ready);
	modport sink   (input valid, op, code, codes_left, output ready);
endinterface

interface sgr_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] attr_foreground;
	logic [23:0] attr_background;
	logic        attr_bg_explicit;
	logic        bold_on;
	logic        reverse_on;
	logic [23:0] cell_foreground;
	logic [23:0] cell_background;
	logic        cell_bg_flag;
	modport source (output valid, attr_foreground, attr_background, attr_bg_explicit,
		bold_on, reverse_on, cell_foreground, cell_background, cell_bg_flag,
		input ready);
	modport sink (input valid, attr_foreground, attr_background, attr_bg_explicit,
		bold_on, reverse_on, cell_foreground, cell_background, cell_bg_flag,
		output ready);
endinterface

interface sgr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sgr_front.sv -----
// ----------------------------------------------------------------------------
// SGR front end
// Accepts codes and classifies them into queue entries with colors resolved.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_front import sgr_pkg::*; (
	sgr_in_if.sink items,
	output logic   push_valid,
	input  logic   push_ready,
	output entry_t push_data
);

	logic [31:0] c;
	logic [7:0]  lo;
	logic [7:0]  off30;
	logic [7:0]  off40;
	logic [7:0]  off90;
	logic [7:0]  off100;

	assign c      = items.code;
	assign lo     = c[7:0];
	assign off30  = lo - 8'd30;
	assign off40  = lo - 8'd40;
	assign off90  = lo - 8'd90;
	assign off100 = lo - 8'd100;

	assign items.ready = push_ready;
	assign push_valid  = items.valid;

	always_comb begin
		push_data            = '0;
		push_data.empty_seq  = items.op;
		push_data.low8       = lo;
		push_data.pal_color  = PALETTE256[lo];
		push_data.sel5       = (c == 32'd5) && (items.codes_left != 8'd0);
		push_data.sel2       = (c == 32'd2) && (items.codes_left >= 8'd3);
		push_data.zero3      = (c == 32'd0) && (items.codes_left >= 8'd3);
		push_data.cls        = CLS_NONE;
		push_data.base_color = BASE_PALETTE[{1'b0, off30[2:0]}];
		if (c == 32'd0) begin
			push_data.cls = CLS_RESET;
		end else if (c == 32'd1) begin
			push_data.cls = CLS_BOLD_SET;
		end else if (c == 32'd22) begin
			push_data.cls = CLS_BOLD_CLR;
		end else if (c == 32'd7) begin
			push_data.cls = CLS_REV_SET;
		end else if (c == 32'd27) begin
			push_data.cls = CLS_REV_CLR;
		end else if (c >= 32'd30 && c <= 32'd37) begin
			push_data.cls        = CLS_FG_PAL;
			push_data.base_color = BASE_PALETTE[{1'b0, off30[2:0]}];
		end else if (c >= 32'd90 && c <= 32'd97) begin
			push_data.cls        = CLS_FG_PAL;
			push_data.base_color = BASE_PALETTE[{1'b1, off90[2:0]}];
		end else if (c == 32'd39) begin
			push_data.cls = CLS_FG_DEF;
		end else if (c >= 32'd40 && c <= 32'd47) begin
			push_data.cls        = CLS_BG_PAL;
			push_data.base_color = BASE_PALETTE[{1'b0, off40[2:0]}];
		end else if (c >= 32'd100 && c <= 32'd107) begin
			push_data.cls        = CLS_BG_PAL;
			push_data.base_color = BASE_PALETTE[{1'b1, off100[2:0]}];
		end else if (c == 32'd49) begin
			push_data.cls = CLS_BG_DEF;
		end else if (c == 32'd38 && items.codes_left != 8'd0) begin
			push_data.cls = CLS_SEL_FG;
		end else if (c == 32'd48 && items.codes_left != 8'd0) begin
			push_data.cls = CLS_SEL_BG;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sgr_queue.sv -----
// ----------------------------------------------------------------------------
// SGR entry queue
// Small FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_queue import sgr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_data
);

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue count beyond depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count not reduced by pop");

endmodule

`default_nettype wire

// ----- rtl/core/sgr_back.sv -----
// ----------------------------------------------------------------------------
// SGR back end
// Attribute state, extended color parser and bold shading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_back import sgr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  entry_t   pop_data,
	sgr_out_if.source results
);

	// attribute and parser state
	color_t     fg_q, bg_q;
	logic       bgx_q, bold_q, rev_q, target_q;
	phase_t     phase_q;
	logic [7:0] red_q, green_q;

	color_t     fg_d, bg_d;
	logic       bgx_d, bold_d, rev_d, target_d;
	phase_t     phase_d;
	logic [7:0] red_d, green_d;
	logic       ord;
	logic       apply;
	color_t     apply_color;

	// pipeline
	logic       en;
	logic       take;
	logic       v_s1, v_s2;
	color_t     fg_s1, bg_s1, cf_s1, cb_s1;
	logic       bgx_s1, bold_s1, rev_s1, ce_s1;
	color_t     fg_s2, bg_s2, cf_s2, cb_s2;
	logic       bgx_s2, bold_s2, rev_s2, ce_s2;
	logic [15:0] pr_s2, pg_s2, pb_s2;
	color_t     cf_raw;
	color_t     shaded;

	function automatic logic [7:0] div100_sat(input logic [15:0] p);
		logic [32:0] prod;
		logic [9:0]  q;
		prod = 33'(p) * 33'(RECIP_100);
		q    = 10'(prod >> RECIP_SHIFT);
		return (q[9:8] != 2'b00) ? 8'hFF : q[7:0];
	endfunction

	assign en        = !results.valid || results.ready;
	assign pop_ready = en;
	assign take      = pop_valid && en;

	always_comb begin
		fg_d        = fg_q;
		bg_d        = bg_q;
		bgx_d       = bgx_q;
		bold_d      = bold_q;
		rev_d       = rev_q;
		target_d    = target_q;
		phase_d     = phase_q;
		red_d       = red_q;
		green_d     = green_q;
		ord         = 1'b0;
		apply       = 1'b0;
		apply_color = pop_data.pal_color;
		if (pop_data.empty_seq) begin
			fg_d    = cfg.def_fg;
			bg_d    = cfg.def_bg;
			bgx_d   = 1'b0;
			bold_d  = 1'b0;
			rev_d   = 1'b0;
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_SELECT: begin
					if (pop_data.sel5) begin
						phase_d = PH_INDEX;
					end else if (pop_data.sel2) begin
						phase_d = PH_FIRST;
					end else begin
						// incomplete form: selector dropped, code taken as ordinary
						phase_d = PH_IDLE;
						ord     = 1'b1;
					end
				end
				PH_INDEX: begin
					apply   = 1'b1;
					phase_d = PH_IDLE;
				end
				PH_FIRST: begin
					if (pop_data.zero3) begin
						phase_d = PH_RED;
					end else begin
						red_d   = pop_data.low8;
						phase_d = PH_GREEN;
					end
				end
				PH_RED: begin
					red_d   = pop_data.low8;
					phase_d = PH_GREEN;
				end
				PH_GREEN: begin
					green_d = pop_data.low8;
					phase_d = PH_BLUE;
				end
				PH_BLUE: begin
					apply       = 1'b1;
					apply_color = {red_q, green_q, pop_data.low8};
					phase_d     = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
					ord     = 1'b1;
				end
			endcase
		end
		if (apply) begin
			if (target_q) begin
				bg_d  = apply_color;
				bgx_d = 1'b1;
			end else begin
				fg_d = apply_color;
			end
		end
		if (ord) begin
			case (pop_data.cls)
				CLS_RESET: begin
					fg_d   = cfg.def_fg;
					bg_d   = cfg.def_bg;
					bgx_d  = 1'b0;
					bold_d = 1'b0;
					rev_d  = 1'b0;
				end
				CLS_BOLD_SET: bold_d = 1'b1;
				CLS_BOLD_CLR: bold_d = 1'b0;
				CLS_REV_SET:  rev_d  = 1'b1;
				CLS_REV_CLR:  rev_d  = 1'b0;
				CLS_FG_PAL:   fg_d   = pop_data.base_color;
				CLS_FG_DEF:   fg_d   = cfg.def_fg;
				CLS_BG_PAL: begin
					bg_d  = pop_data.base_color;
					bgx_d = 1'b1;
				end
				CLS_BG_DEF: begin
					bg_d  = cfg.def_bg;
					bgx_d = 1'b0;
				end
				CLS_SEL_FG: begin
					target_d = 1'b0;
					phase_d  = PH_SELECT;
				end
				CLS_SEL_BG: begin
					target_d = 1'b1;
					phase_d  = PH_SELECT;
				end
				default: ;
			endcase
		end
	end

	// reverse video: foreground from explicit background or black
	assign cf_raw = rev_d ? (bgx_d ? bg_d : '0) : fg_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= DEF_FG_RESET;
			bg_q     <= '0;
			bgx_q    <= 1'b0;
			bold_q   <= 1'b0;
			rev_q    <= 1'b0;
			target_q <= 1'b0;
			phase_q  <= PH_IDLE;
			red_q    <= '0;
			green_q  <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			results.valid <= 1'b0;
		end else begin
			if (take) begin
				fg_q     <= fg_d;
				bg_q     <= bg_d;
				bgx_q    <= bgx_d;
				bold_q   <= bold_d;
				rev_q    <= rev_d;
				target_q <= target_d;
				phase_q  <= phase_d;
				red_q    <= red_d;
				green_q  <= green_d;
			end
			if (en) begin
				v_s1          <= pop_valid;
				v_s2          <= v_s1;
				results.valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fg_s1   <= fg_d;
			bg_s1   <= bg_d;
			bgx_s1  <= bgx_d;
			bold_s1 <= bold_d;
			rev_s1  <= rev_d;
			cf_s1   <= cf_raw;
			cb_s1   <= rev_d ? fg_d : bg_d;
			ce_s1   <= rev_d | bgx_d;

			fg_s2   <= fg_s1;
			bg_s2   <= bg_s1;
			bgx_s2  <= bgx_s1;
			bold_s2 <= bold_s1;
			rev_s2  <= rev_s1;
			cf_s2   <= cf_s1;
			cb_s2   <= cb_s1;
			ce_s2   <= ce_s1;
			pr_s2   <= 16'(cf_s1[23:16]) * 16'(cfg.bold_pct);
			pg_s2   <= 16'(cf_s1[15:8]) * 16'(cfg.bold_pct);
			pb_s2   <= 16'(cf_s1[7:0]) * 16'(cfg.bold_pct);

			results.attr_foreground  <= fg_s2;
			results.attr_background  <= bg_s2;
			results.attr_bg_explicit <= bgx_s2;
			results.bold_on          <= bold_s2;
			results.reverse_on       <= rev_s2;
			results.cell_foreground  <= bold_s2 ? shaded : cf_s2;
			results.cell_background  <= cb_s2;
			results.cell_bg_flag     <= ce_s2;
		end
	end

	assign shaded = {div100_sat(pr_s2), div100_sat(pg_s2), div100_sat(pb_s2)};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en) |=> (v_s1 && $stable(cf_s1) && $stable(fg_s1)))
		else $error("stage 1 changed while stalled");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_s1)
		else $error("popped transaction lost");

	a_rev_explicit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rev_s1) |-> ce_s1)
		else $error("reverse cell without explicit background");

	a_plain_fg: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.bold_on && !results.reverse_on)
		|-> (results.cell_foreground == results.attr_foreground))
		else $error("cell foreground differs without bold or reverse");

endmodule

`default_nettype wire

// ----- rtl/core/sgr_color_attribute_decoder.sv -----
// ----------------------------------------------------------------------------
// SGR color attribute decoder
// Decodes SGR codes into text attributes and shaded cell colors.
// ----------------------------------------------------------------------------
// Usage:
//   items   - one SGR code per transaction with op, code and codes_left;
//             op set marks an empty sequence and resets the attributes.
//   results - one transaction per item: attributes after the item and the
//             colors a written cell would get after reverse and bold shading.
//   cfg     - register writes: index 0 default foreground, 1 default
//             background, 2 bold gain in percent; other indexes are ignored.
//             Writes are always taken; write only while no item is in flight.
// Timing: one item per cycle while results.ready is high. An accepted item passes
//   through the queue, attribute update, shading multiply, then the
//   output register with the divide-by-100 step.
// Stall: the output register holds while a valid result waits with results.ready low; the back end
//   stops, and the front keeps taking items until the four-entry queue fills.
// Reset: attributes, parser and queue are cleared, the registers take their
//   reset values; no clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_color_attribute_decoder import sgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sgr_in_if.sink    items,
	sgr_out_if.source results,
	sgr_cfg_if.sink   cfg
);

	cfg_t   cfg_q;
	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.def_fg   <= DEF_FG_RESET;
			cfg_q.def_bg   <= DEF_BG_RESET;
			cfg_q.bold_pct <= BOLD_PCT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DEF_FG:   cfg_q.def_fg   <= cfg.data;
				CFG_DEF_BG:   cfg_q.def_bg   <= cfg.data;
				CFG_BOLD_PCT: cfg_q.bold_pct <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	sgr_front u_front (
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

endmodule

`default_nettype wire

// ----- verif/sgr_color_attribute_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// SGR color attribute decoder testbench
// Streams SGR codes through the decoder under sender and receiver stalls. It
// predicts every result, including the 38/48 extended-color parser and the
// reverse and bold cell colors, and compares each result transaction
// field by field. The default colors and bold gain are reprogrammed between
// phases, with extreme values among the settings.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_color_attribute_decoder_tb import sgr_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_REPORTS    = 10;

	localparam logic [1:0] CFG_NO_REG = 2'd3;

	localparam color_t     FG_AT_RESET  = 24'hD8DEE9;
	localparam color_t     BG_AT_RESET  = 24'h000000;
	localparam logic [7:0] PCT_AT_RESET = 8'd116;

	localparam color_t TINTS [16] = '{
		24'h15161E, 24'hF7768E, 24'h9ECE6A, 24'hE0AF68,
		24'h7AA2F7, 24'hBB9AF7, 24'h7DCFFF, 24'hC0CAF5,
		24'h414868, 24'hFF899D, 24'hB9F27C, 24'hF4C97A,
		24'h8DB0FF, 24'hC7A9FF, 24'h9BE8FF, 24'hF4F7FF
	};

	localparam logic [7:0] LEVELS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

	typedef struct packed {
		color_t attr_fg;
		color_t attr_bg;
		logic   attr_bgx;
		logic   bold;
		logic   rev;
		color_t cell_fg;
		color_t cell_bg;
		logic   cell_bgx;
	} sgr_view_t;

	logic clk;
	logic arst_n;

	sgr_in_if  items();
	sgr_out_if results();
	sgr_cfg_if cfg();

	sgr_color_attribute_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	// register shadow
	color_t     reg_def_fg;
	color_t     reg_def_bg;
	logic [7:0] reg_bold_pct;

	// attribute and parser shadow
	color_t     st_fg;
	color_t     st_bg;
	logic       st_bgx;
	logic       st_bold;
	logic       st_rev;
	phase_t     st_phase;
	logic       st_to_bg;
	logic [7:0] st_red;
	logic [7:0] st_green;

	sgr_view_t pending_views [$];
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        items_sent    = 0;
	int        faults        = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_attrs();
		st_fg   = reg_def_fg;
		st_bg   = reg_def_bg;
		st_bgx  = 1'b0;
		st_bold = 1'b0;
		st_rev  = 1'b0;
	endfunction

	function automatic void store_ext_color(color_t col);
		if (st_to_bg) begin
			st_bg  = col;
			st_bgx = 1'b1;
		end else begin
			st_fg = col;
		end
	endfunction

	function automatic void plain_code(logic [31:0] c, logic [7:0] left);
		if (c == 0) clear_attrs();
		else if (c == 1) st_bold = 1'b1;
		else if (c == 22) st_bold = 1'b0;
		else if (c == 7) st_rev = 1'b1;
		else if (c == 27) st_rev = 1'b0;
		else if (c >= 30 && c <= 37) st_fg = TINTS[4'(c - 30)];
		else if (c >= 90 && c <= 97) st_fg = TINTS[4'(8 + c - 90)];
		else if (c == 39) st_fg = reg_def_fg;
		else if (c >= 40 && c <= 47) begin
			st_bg  = TINTS[4'(c - 40)];
			st_bgx = 1'b1;
		end else if (c >= 100 && c <= 107) begin
			st_bg  = TINTS[4'(8 + c - 100)];
			st_bgx = 1'b1;
		end else if (c == 49) begin
			st_bg  = reg_def_bg;
			st_bgx = 1'b0;
		end else if ((c == 38 || c == 48) && left >= 1) begin
			st_to_bg = (c == 48);
			st_phase = PH_SELECT;
		end
	endfunction

	// advances the shadow by one code and returns the attributes and cell colors
	function automatic sgr_view_t decode_code(logic op, logic [31:0] c, logic [7:0] left);
		sgr_view_t  v;
		color_t     ext;
		color_t     cf;
		int         idx;
		int         cube;
		int         chan;
		logic [7:0] gray;
		if (op) begin
			clear_attrs();
			st_phase = PH_IDLE;
		end else begin
			case (st_phase)
				PH_SELECT: begin
					if (c == 5 && left >= 1) st_phase = PH_INDEX;
					else if (c == 2 && left >= 3) st_phase = PH_FIRST;
					else begin
						st_phase = PH_IDLE;
						plain_code(c, left);
					end
				end
				PH_INDEX: begin
					idx = int'(c[7:0]);
					if (idx < 16) begin
						ext = TINTS[4'(idx)];
					end else if (idx < 232) begin
						cube = idx - 16;
						ext  = {LEVELS[3'(cube / 36)], LEVELS[3'((cube / 6) % 6)],
							LEVELS[3'(cube % 6)]};
					end else begin
						gray = 8'(8 + (idx - 232) * 10);
						ext  = {gray, gray, gray};
					end
					store_ext_color(ext);
					st_phase = PH_IDLE;
				end
				PH_FIRST: begin
					// leading zero of the colon form is a color-space id
					if (c == 0 && left >= 3) st_phase = PH_RED;
					else begin
						st_red   = c[7:0];
						st_phase = PH_GREEN;
					end
				end
				PH_RED: begin
					st_red   = c[7:0];
					st_phase = PH_GREEN;
				end
				PH_GREEN: begin
					st_green = c[7:0];
					st_phase = PH_BLUE;
				end
				PH_BLUE: begin
					store_ext_color({st_red, st_green, c[7:0]});
					st_phase = PH_IDLE;
				end
				default: begin
					st_phase = PH_IDLE;
					plain_code(c, left);
				end
			endcase
		end

		cf         = st_fg;
		v.cell_bg  = st_bg;
		v.cell_bgx = st_bgx;
		if (st_rev) begin
			cf         = st_bgx ? st_bg : 24'h000000;
			v.cell_bg  = st_fg;
			v.cell_bgx = 1'b1;
		end
		if (st_bold) begin
			for (int ch = 0; ch < 3; ch++) begin
				chan = int'(cf[ch*8 +: 8]) * int'(reg_bold_pct) / 100;
				if (chan > 255) chan = 255;
				cf[ch*8 +: 8] = 8'(chan);
			end
		end
		v.attr_fg  = st_fg;
		v.attr_bg  = st_bg;
		v.attr_bgx = st_bgx;
		v.bold     = st_bold;
		v.rev      = st_rev;
		v.cell_fg  = cf;
		return v;
	endfunction

	// result receiver with random back-pressure
	initial begin
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			results.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		sgr_view_t got;
		sgr_view_t want;
		if (arst_n && results.valid === 1'b1 && results.ready === 1'b1) begin
			got = '{results.attr_foreground, results.attr_background, results.attr_bg_explicit,
				results.bold_on, results.reverse_on, results.cell_foreground,
				results.cell_background, results.cell_bg_flag};
			if (pending_views.size() == 0) begin
				if (faults < MAX_REPORTS)
					$display("unexpected result transaction: fg %h bg %h", got.attr_fg, got.attr_bg);
				faults++;
			end else begin
				want = pending_views.pop_front();
				if (got !== want) begin
					if (faults < MAX_REPORTS) begin
						$display("mismatch exp: afg %h abg %h abx %b bold %b rev %b cfg %h cbg %h cbx %b",
							want.attr_fg, want.attr_bg, want.attr_bgx, want.bold, want.rev,
							want.cell_fg, want.cell_bg, want.cell_bgx);
						$display("         got: afg %h abg %h abx %b bold %b rev %b cfg %h cbg %h cbx %b",
							got.attr_fg, got.attr_bg, got.attr_bgx, got.bold, got.rev,
							got.cell_fg, got.cell_bg, got.cell_bgx);
					end
					faults++;
				end
			end
		end
	end

	// ends the run when no channel has moved a transaction for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((items.valid && items.ready) || (results.valid && results.ready) ||
				(cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("sgr_color_attribute_decoder verification failed");
		$finish;
	end

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic send_code(logic op, logic [31:0] c, logic [7:0] left);
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid      <= 1'b1;
		items.op         <= op;
		items.code       <= c;
		items.codes_left <= left;
		do @(posedge clk); while (items.ready !== 1'b1);
		pending_views.push_back(decode_code(op, c, left));
		items_sent++;
	endtask

	// stop sending and let every result come out
	task automatic drain();
		items.valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_DEF_FG:   reg_def_fg = data;
			CFG_DEF_BG:   reg_def_bg = data;
			CFG_BOLD_PCT: reg_bold_pct = data[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(color_t fg, color_t bg, logic [7:0] pct);
		logic [31:0] junk;
		junk = $urandom;
		drain();
		write_reg(CFG_DEF_FG, fg);
		write_reg(CFG_DEF_BG, bg);
		write_reg(CFG_BOLD_PCT, {junk[15:0], pct});
		write_reg(CFG_NO_REG, 24'($urandom));
	endtask

	function automatic logic [31:0] pick_plain_code();
		case ($urandom_range(11))
			0:  return 32'd0;
			1:  return 32'd1;
			2:  return 32'd22;
			3:  return 32'd7;
			4:  return 32'd27;
			5:  return 32'd30 + $urandom_range(7);
			6:  return 32'd90 + $urandom_range(7);
			7:  return 32'd39;
			8:  return 32'd40 + $urandom_range(7);
			9:  return 32'd100 + $urandom_range(7);
			10: return 32'd49;
			default: return $urandom_range(1) ? $urandom : $urandom_range(127);
		endcase
	endfunction

	// operand byte, sometimes with junk above the low eight bits
	function automatic logic [31:0] pick_operand();
		logic [31:0] hi;
		hi = $urandom;
		if ($urandom_range(3) == 0) return {hi[31:8], 8'($urandom)};
		return {24'h0, 8'($urandom)};
	endfunction

	task automatic send_random_sequence();
		logic [31:0] seq [$];
		int          pick;
		int          pieces;
		int          rest;
		int          extra;
		logic [31:0] sel;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_code(1'b1, $urandom, 8'($urandom));
		end else if (pick < 18) begin
			pieces = $urandom_range(1, 4);
			repeat (pieces)
				send_code(1'b0, $urandom_range(1) ? $urandom : $urandom_range(127),
					8'($urandom));
		end else begin
			pieces = $urandom_range(1, 4);
			repeat (pieces) begin
				pick = $urandom_range(99);
				sel  = $urandom_range(1) ? 32'd48 : 32'd38;
				if (pick < 45) begin
					seq.push_back(pick_plain_code());
				end else if (pick < 65) begin
					seq.push_back(sel);
					seq.push_back(32'd5);
					seq.push_back(pick_operand());
				end else begin
					seq.push_back(sel);
					seq.push_back(32'd2);
					if (pick >= 90) seq.push_back(32'd0);
					repeat (3) seq.push_back(pick_operand());
				end
			end
			// broken sequence: cut short so forms end up incomplete
			if ($urandom_range(99) < 12)
				seq = seq[0:$urandom_range(seq.size() - 1)];
			extra = ($urandom_range(9) == 0) ? $urandom_range(300) : 0;
			foreach (seq[i]) begin
				rest = seq.size() - 1 - i + extra;
				send_code(1'b0, seq[i], (rest > 255) ? 8'd255 : 8'(rest));
			end
		end
	endtask

	task automatic test_directed_codes();
		send_code(1'b0, 32'd1, 8'd8);
		send_code(1'b0, 32'd7, 8'd7);
		send_code(1'b0, 32'd41, 8'd6);
		// 38;5;n with junk above the index byte
		send_code(1'b0, 32'd38, 8'd5);
		send_code(1'b0, 32'd5, 8'd4);
		send_code(1'b0, 32'hFFFF_FFC4, 8'd3);
		// selector with nothing after it
		send_code(1'b0, 32'd48, 8'd0);
		// 48;2;0;r;g;b colon form
		send_code(1'b0, 32'd48, 8'd9);
		send_code(1'b0, 32'd2, 8'd8);
		send_code(1'b0, 32'd0, 8'd7);
		send_code(1'b0, 32'h0000_012C, 8'd6);
		send_code(1'b0, 32'h8000_01FF, 8'd5);
		send_code(1'b0, 32'hFFFF_FF80, 8'd4);
		// 2 without three codes left falls back to a plain code
		send_code(1'b0, 32'd38, 8'd3);
		send_code(1'b0, 32'd2, 8'd2);
		// fallback code that opens a new form
		send_code(1'b0, 32'd38, 8'd2);
		send_code(1'b0, 32'd48, 8'd1);
		send_code(1'b0, 32'd5, 8'd0);
		// empty sequence abandons a form in progress
		send_code(1'b0, 32'd48, 8'd2);
		send_code(1'b0, 32'd5, 8'd1);
		send_code(1'b1, 32'hFFFF_FFFF, 8'hFF);
		// zero after 38;2 with too few left is red, not a color-space id
		send_code(1'b0, 32'd38, 8'd4);
		send_code(1'b0, 32'd2, 8'd3);
		send_code(1'b0, 32'd0, 8'd2);
		send_code(1'b0, 32'hFFFF_FFFF, 8'd1);
		send_code(1'b0, 32'd7, 8'd0);
		send_code(1'b0, 32'hFFFF_FFFF, 8'd255);
	endtask

	task automatic test_register_settings();
		int goal;
		for (int s = 0; s < 4; s++) begin
			case (s)
				0: set_config(24'h000000, 24'h000000, 8'd0);
				1: set_config(24'hFFFFFF, 24'hFFFFFF, 8'd255);
				2: set_config(24'($urandom), 24'($urandom), 8'd100);
				default: set_config(FG_AT_RESET, BG_AT_RESET, PCT_AT_RESET);
			endcase
			goal = items_sent + 50;
			while (items_sent < goal) send_random_sequence();
		end
	endtask

	task automatic test_random_traffic(int count);
		int goal;
		set_config(24'($urandom), 24'($urandom), 8'($urandom));
		goal = items_sent + count;
		while (items_sent < goal) send_random_sequence();
	endtask

	initial begin
		arst_n           = 1'b0;
		items.valid      = 1'b0;
		items.op         = 1'b0;
		items.code       = 32'd0;
		items.codes_left = 8'd0;
		cfg.valid        = 1'b0;
		cfg.index        = CFG_DEF_FG;
		cfg.data         = 24'd0;

		reg_def_fg   = FG_AT_RESET;
		reg_def_bg   = BG_AT_RESET;
		reg_bold_pct = PCT_AT_RESET;
		clear_attrs();
		st_phase = PH_IDLE;
		st_to_bg = 1'b0;
		st_red   = 8'd0;
		st_green = 8'd0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_idling(24, 48);
		test_directed_codes();
		test_register_settings();
		test_random_traffic(500);
		set_idling(48, 24);
		test_random_traffic(550);
		set_idling(0, 0);
		test_random_traffic(500);
		drain();

		if (faults == 0)
			$display("sgr_color_attribute_decoder verification clean");
		else
			$display("sgr_color_attribute_decoder verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/sgr_pkg.sv
rtl/core/sgr_if.sv
rtl/core/sgr_front.sv
rtl/core/sgr_queue.sv
rtl/core/sgr_back.sv
rtl/core/sgr_color_attribute_decoder.sv
verif/sgr_color_attribute_decoder_tb.sv
